// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; each expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wea_pkg.sv =====
package wea_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SAMPLE_W   = 32;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int AVG_W      = 40;
    localparam int CFG_W      = 7;
    localparam int COUNT_W    = 7;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

endpackage

// ===== hw/rtl/wea_ram.sv =====
module wea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/windowed_error_averager.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------
// input    | in_valid / in_ready     | error_value[31:0], clear
// output   | out_valid / out_ready   | average[39:0] signed, stored_count[6:0]
// config   | cfg_we (no wait)        | cfg_wdata[6:0] = window_size
//
// Clear and an empty window skip the divider; a filling window runs it once and a
// full window twice. It is one restoring divider that makes one quotient bit per
// cycle over a 38-bit dividend. A full window first reads the oldest sample from
// the ring, whose read is registered.
// Reset (rst_n, async, active low) empties the window, zeroes the average and
// sets window_size to 64. A stalled output holds the finished item; the next
// item is accepted meanwhile and waits in its final step until the slot frees.
module windowed_error_averager
    import wea_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [SAMPLE_W-1:0]       error_value,
    input  logic                      clear,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [AVG_W-1:0]   average,
    output logic [COUNT_W-1:0]        stored_count,
    input  logic                      cfg_we,
    input  logic [CFG_W-1:0]          cfg_wdata
);

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_APPLY,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_PART,
        OP_OLD,
        OP_NEW
    } op_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [CFG_W-1:0]     window_reg, window_next;
    logic [SLOT_W-1:0]    newest_reg, newest_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [AVG_W-1:0]     avg_reg, avg_next;
    logic [SAMPLE_W-1:0]  x_reg, x_next;
    logic [SUM_W-1:0]     dvd_reg, dvd_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]     out_avg_reg, out_avg_next;
    logic [CNT_W-1:0]     out_count_reg, out_count_next;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [SAMPLE_W-1:0]  ram_wdata;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [SAMPLE_W-1:0]  ram_rdata;

    logic [CNT_W-1:0]     eff_window;
    logic [SLOT_W-1:0]    next_slot;
    logic [CNT_W-1:0]     back;
    logic [CNT_W:0]       newest_ext;
    logic [CNT_W:0]       trial;
    logic                 trial_ge;

    wea_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Zero or oversized window falls back to the full ring.
    assign eff_window = (window_reg == '0 || int'(window_reg) > MAX_WINDOW)
                        ? CNT_W'(MAX_WINDOW) : CNT_W'(window_reg);

    assign next_slot = (newest_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0 : newest_reg + 1'b1;

    // Oldest slot sits count-1 places behind the newest, wrapping around the ring.
    assign back       = count_reg - 1'b1;
    assign newest_ext = (CNT_W + 1)'(newest_reg);
    assign ram_raddr  = ((CNT_W + 1)'(back) <= newest_ext)
                        ? SLOT_W'(newest_ext - (CNT_W + 1)'(back))
                        : SLOT_W'(newest_ext + (CNT_W + 1)'(MAX_WINDOW)
                                  - (CNT_W + 1)'(back));

    // Shared restoring divider step: one quotient bit per cycle.
    assign trial    = {rem_reg, dvd_reg[SUM_W-1]};
    assign trial_ge = trial >= (CNT_W + 1)'(count_reg);

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign average      = out_avg_reg;
    assign stored_count = COUNT_W'(out_count_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        window_next    = cfg_we ? cfg_wdata : window_reg;
        newest_next    = newest_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        x_next         = x_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_avg_next   = out_avg_reg;
        out_count_next = out_count_reg;
        ram_we         = 1'b0;
        ram_waddr      = next_slot;
        ram_wdata      = x_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next       = error_value;
                    dvd_next     = sum_reg;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    op_next      = OP_PART;
                    priority if (clear)
                    begin
                        newest_next = '0;
                        count_next  = '0;
                        sum_next    = '0;
                        avg_next    = '0;
                        state_next  = S_OUT;
                    end
                    else if (count_reg == '0)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = '0;
                        ram_wdata   = error_value;
                        newest_next = '0;
                        count_next  = CNT_W'(1);
                        sum_next    = SUM_W'(error_value);
                        state_next  = S_OUT;
                    end
                    else if (count_reg < eff_window)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // Oldest sample is out of the ring now; the count stays put.
                sum_next     = sum_reg - SUM_W'(ram_rdata) + SUM_W'(x_reg);
                dvd_next     = SUM_W'(ram_rdata);
                rem_next     = '0;
                div_cnt_next = '0;
                op_next      = OP_OLD;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                rem_next     = trial_ge ? CNT_W'(trial - (CNT_W + 1)'(count_reg))
                                        : CNT_W'(trial);
                dvd_next     = {dvd_reg[SUM_W-2:0], trial_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                unique case (op_reg)
                    OP_PART:
                    begin
                        avg_next    = AVG_W'(dvd_reg);
                        ram_we      = 1'b1;
                        newest_next = next_slot;
                        count_next  = count_reg + 1'b1;
                        sum_next    = sum_reg + SUM_W'(x_reg);
                        state_next  = S_OUT;
                    end
                    OP_OLD:
                    begin
                        avg_next     = avg_reg - AVG_W'(dvd_reg);
                        dvd_next     = SUM_W'(x_reg);
                        rem_next     = '0;
                        div_cnt_next = '0;
                        op_next      = OP_NEW;
                        state_next   = S_DIV;
                    end
                    OP_NEW:
                    begin
                        avg_next    = avg_reg + AVG_W'(dvd_reg);
                        ram_we      = 1'b1;
                        newest_next = next_slot;
                        state_next  = S_OUT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_OUT:
            begin
                // Hold until the output slot is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = avg_reg;
                    out_count_next = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_PART;
            window_reg    <= CFG_W'(MAX_WINDOW);
            newest_reg    <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            avg_reg       <= '0;
            x_reg         <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_avg_reg   <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            window_reg    <= window_next;
            newest_reg    <= newest_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            avg_reg       <= avg_next;
            x_reg         <= x_next;
            dvd_reg       <= dvd_next;
            rem_reg       <= rem_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            out_avg_reg   <= out_avg_next;
            out_count_reg <= out_count_next;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, int'(count_reg) <= MAX_WINDOW,
                   "held count exceeds ring depth")
    `ASSERT_IMPL(a_div_nonzero, state_reg == S_DIV,
                 count_reg != '0 && rem_reg < count_reg,
                 "divider running with bad divisor or remainder")
    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                 "item accepted while previous item still in work")
    `ASSERT_IMPL(a_out_from_seq, $rose(out_valid_reg), $past(state_reg == S_OUT),
                 "output loaded outside the final step")

endmodule

// ===== tb/sv/wea_checker.sv =====
`timescale 1ns / 100ps

module wea_checker
    import wea_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [SAMPLE_W-1:0]     error_value,
    input  logic                    clear,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic signed [AVG_W-1:0] average,
    input  logic [COUNT_W-1:0]      stored_count,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_wdata,
    output int                      fail_count,
    output int                      pending,
    output int                      checked
);

    typedef struct packed {
        logic [AVG_W-1:0]   average;
        logic [COUNT_W-1:0] count;
    } avg_result_t;

    avg_result_t         awaited_averages[$];
    avg_result_t         want;
    logic [SAMPLE_W-1:0] ring [MAX_WINDOW];
    logic [SLOT_W-1:0]   newest;
    logic [COUNT_W-1:0]  held;
    logic [SUM_W-1:0]    sum;
    logic [AVG_W-1:0]    avg;
    logic [CFG_W-1:0]    window;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    task automatic advance_average(input logic [SAMPLE_W-1:0] x, input logic clr);
        logic [COUNT_W-1:0]  limit;
        logic [SLOT_W-1:0]   oldest;
        logic [SAMPLE_W-1:0] old;
        // zero and oversized windows fall back to the full ring
        limit = (window == '0 || window > MAX_WINDOW) ? COUNT_W'(MAX_WINDOW) : window;
        if (clr)
        begin
            newest = '0;
            held   = '0;
            sum    = '0;
            avg    = '0;
        end
        else if (held == '0)
        begin
            newest  = '0;
            ring[0] = x;
            held    = COUNT_W'(1);
            sum     = SUM_W'(x);
        end
        else if (held < limit)
        begin
            // average of what was held before this sample
            avg          = AVG_W'(sum / held);
            newest       = newest + 1'b1;
            ring[newest] = x;
            held         = held + 1'b1;
            sum          = sum + x;
        end
        else
        begin
            // full or shrunk window: swap one oldest sample for the new one
            oldest       = newest - SLOT_W'(held - 1'b1);
            old          = ring[oldest];
            avg          = avg - AVG_W'(old / held) + AVG_W'(x / held);
            sum          = sum - old + x;
            newest       = newest + 1'b1;
            ring[newest] = x;
        end
        awaited_averages.insert(awaited_averages.size(), avg_result_t'{avg, held});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest = '0;
            held   = '0;
            sum    = '0;
            avg    = '0;
            window = CFG_W'(MAX_WINDOW);
            awaited_averages.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_averages.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual average %0d count %0d",
                             $time, average, stored_count);
                end
                else
                begin
                    want = awaited_averages.pop_front();
                    if (average !== want.average)
                    begin
                        fail_count++;
                        $display("%0t: average mismatch: expected %0d, actual %0d",
                                 $time, want.average, average);
                    end
                    if (stored_count !== want.count)
                    begin
                        fail_count++;
                        $display("%0t: stored_count mismatch: expected %0d, actual %0d",
                                 $time, want.count, stored_count);
                    end
                    checked++;
                end
            end
            if (cfg_we)
                window = cfg_wdata;
            if (in_valid && in_ready)
                advance_average(error_value, clear);
            pending = awaited_averages.size();
        end
    end

endmodule

// ===== tb/sv/windowed_error_averager_tb.sv =====
`timescale 1ns / 100ps

module windowed_error_averager_tb;
    import wea_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 38;
    localparam int MAX_GAP      = 100;
    localparam int CLEAR_PCT    = 1;
    localparam int RANDOM_ITEMS = 1800;
    localparam int SETTLE       = 4;
    localparam int DRAIN_CYCLES = 100;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic [SAMPLE_W-1:0]     error_value = '0;
    logic                    clear       = 1'b0;
    logic                    out_ready   = 1'b0;
    logic                    cfg_we      = 1'b0;
    logic [CFG_W-1:0]        cfg_wdata   = '0;
    logic                    in_ready;
    logic                    out_valid;
    logic signed [AVG_W-1:0] average;
    logic [COUNT_W-1:0]      stored_count;

    int fail_count;
    int pending;
    int checked;
    int sent          = 0;
    int clears        = 0;
    int settings_used = 0;
    int hold_left     = 0;
    int quiet         = 0;
    bit steady        = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    windowed_error_averager i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .error_value  (error_value),
        .clear        (clear),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .average      (average),
        .stored_count (stored_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    wea_checker i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .error_value  (error_value),
        .clear        (clear),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .average      (average),
        .stored_count (stored_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(255);
            1:       return '1 - $urandom_range(255);
            2:       return $urandom_range(1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [SAMPLE_W-1:0] value, input logic clr);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(1, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        error_value <= value;
        clear       <= clr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        if (clr)
            clears++;
    endtask

    // drop valid and wait until every outstanding item has returned
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] size);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                while (hold_left > 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
            end
            else
                out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("%0t: watchdog: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        int               phase;
        int               phase_len;
        int               stop_at;
        logic [CFG_W-1:0] size;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty, filling and clear paths at the reset window
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item(32'd1, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item('1, 1'b1);
        send_item('0, 1'b1);
        send_item('1, 1'b0);
        // one-sample window is full from the first sample
        set_window(7'd1);
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item(32'h1234_5678, 1'b0);
        set_window(7'd3);
        repeat (3) send_item('1, 1'b0);
        // shrink below the held count
        set_window(7'd1);
        repeat (3) send_item(pick_sample(), 1'b0);
        set_window('0);
        repeat (2) send_item('1, 1'b0);
        set_window(7'h7F);
        send_item(32'h0001_0000, 1'b0);
        set_window(7'd65);
        send_item('1, 1'b0);

        stop_at = sent + RANDOM_ITEMS;
        phase   = 0;
        while (sent < stop_at)
        begin
            case (phase % 8)
                0:       size = CFG_W'(MAX_WINDOW);
                1:       size = 7'd1;
                2:       size = CFG_W'($urandom_range(2, 8));
                3:       size = '0;
                4:       size = CFG_W'($urandom_range(MAX_WINDOW + 1, 127));
                default: size = CFG_W'($urandom_range(1, MAX_WINDOW));
            endcase
            set_window(size);
            steady    = (phase == 5);
            phase_len = $urandom_range(40, 140);
            for (int n = 0; n < phase_len; n++)
            begin
                if (phase == 3 && n == phase_len / 2)
                    hold_left = HOLD_CYCLES;
                if (phase == 6 && n == phase_len / 2)
                    drain();
                send_item(pick_sample(), $urandom_range(99) < CLEAR_PCT);
            end
            phase++;
        end
        steady = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d items (%0d clears) across %0d window settings",
                 sent, clears, settings_used);
        $display("%0d results compared, %0d failures", checked, fail_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
